@@ rtl/core/sgi_pkg.sv @@
// Shared widths, codes and stage payload types for the segment intersection pipeline.
// No dependencies; every module in rtl/core imports this package.
package sgi_pkg;

   localparam int CW      = 16;
   localparam int FB      = 16;
   localparam int FIELD_W = 16;
   localparam int OUT_W   = 32;
   localparam int THR_W   = 10;
   localparam int DIFF_W  = CW + 1;
   localparam int PROD_W  = 2 * DIFF_W + 1;
   localparam int PD_W    = CW + PROD_W + 1;
   localparam int ND_W    = PROD_W + DIFF_W;
   localparam int NUM_W   = ND_W + 1;
   localparam int XW      = NUM_W + FB;
   localparam int QB      = CW + 2 + FB;
   localparam int LANES   = 4;

   localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

   typedef logic signed [CW-1:0]     coord_type;
   typedef logic signed [DIFF_W-1:0] diff_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [PD_W-1:0]   pd_type;
   typedef logic signed [ND_W-1:0]   nd_type;
   typedef logic signed [NUM_W-1:0]  num_type;
   typedef logic [PROD_W-1:0]        den_type;
   typedef logic [NUM_W-1:0]         mag_type;
   typedef logic [QB-1:0]            quo_type;

   typedef enum logic [1:0] {
      MEET_NONE  = 2'd0,
      MEET_POINT = 2'd1,
      MEET_SPAN  = 2'd2
   } meet_type;

   typedef struct packed {
      coord_type ax0;
      coord_type ay0;
      coord_type bx0;
      coord_type by0;
      diff_type  ux;
      diff_type  uy;
      diff_type  vx;
      diff_type  vy;
      diff_type  wx;
      diff_type  wy;
      diff_type  ex;
      diff_type  ey;
   } geom_type;

   typedef struct packed {
      geom_type g;
      prod_type d;
      prod_type cuw;
      prod_type cvw;
   } cross_type;

   typedef struct packed {
      meet_type  kind;
      coord_type px;
      coord_type py;
      prod_type  n0;
      prod_type  n1;
      diff_type  dirx;
      diff_type  diry;
      den_type   den;
   } plan_type;

   typedef struct packed {
      meet_type                kind;
      mag_type [LANES-1:0]     mag;
      logic    [LANES-1:0]     neg;
      den_type                 den;
   } numer_type;

endpackage

@@ rtl/core/sgi_front.sv @@
// Front stages: input capture, endpoint differences, perp products.
// Depends on sgi_pkg.
module sgi_front import sgi_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  coord_type ax0,
   input  coord_type ay0,
   input  coord_type ax1,
   input  coord_type ay1,
   input  coord_type bx0,
   input  coord_type by0,
   input  coord_type bx1,
   input  coord_type by1,
   output logic      out_valid,
   output cross_type out_data
);

   logic      v1_ff, v2_ff, v3_ff;
   coord_type ax0_ff, ay0_ff, ax1_ff, ay1_ff, bx0_ff, by0_ff, bx1_ff, by1_ff;
   geom_type  g_ff, g_in;
   cross_type x_ff, x_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      ax0_ff <= ax0;
      ay0_ff <= ay0;
      ax1_ff <= ax1;
      ay1_ff <= ay1;
      bx0_ff <= bx0;
      by0_ff <= by0;
      bx1_ff <= bx1;
      by1_ff <= by1;
      g_ff   <= g_in;
      x_ff   <= x_in;
   end

   always_comb begin
      g_in.ax0 = ax0_ff;
      g_in.ay0 = ay0_ff;
      g_in.bx0 = bx0_ff;
      g_in.by0 = by0_ff;
      g_in.ux  = diff_type'(ax1_ff) - diff_type'(ax0_ff);
      g_in.uy  = diff_type'(ay1_ff) - diff_type'(ay0_ff);
      g_in.vx  = diff_type'(bx1_ff) - diff_type'(bx0_ff);
      g_in.vy  = diff_type'(by1_ff) - diff_type'(by0_ff);
      g_in.wx  = diff_type'(ax0_ff) - diff_type'(bx0_ff);
      g_in.wy  = diff_type'(ay0_ff) - diff_type'(by0_ff);
      g_in.ex  = diff_type'(ax1_ff) - diff_type'(bx0_ff);
      g_in.ey  = diff_type'(ay1_ff) - diff_type'(by0_ff);
   end

   always_comb begin
      x_in.g   = g_ff;
      x_in.d   = prod_type'(g_ff.ux * g_ff.vy) - prod_type'(g_ff.uy * g_ff.vx);
      x_in.cuw = prod_type'(g_ff.ux * g_ff.wy) - prod_type'(g_ff.uy * g_ff.wx);
      x_in.cvw = prod_type'(g_ff.vx * g_ff.wy) - prod_type'(g_ff.vy * g_ff.wx);
   end

   assign out_valid = v3_ff;
   assign out_data  = x_ff;

endmodule

@@ rtl/core/sgi_classify.sv @@
// Case split: skew, parallel, point and collinear overlap; picks base point and parameters.
// Depends on sgi_pkg.
module sgi_classify import sgi_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [THR_W-1:0] threshold,
   input  logic             in_valid,
   input  cross_type        in_data,
   output logic             out_valid,
   output plan_type         out_data
);

   logic     v_ff;
   plan_type p_ff, p_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   always_comb begin
      geom_type g;
      prod_type dpos, ns, nt;
      logic     par, upt, vpt;
      diff_type wa, va, cden, cn0, cn1, tmp;
      g    = in_data.g;
      p_in = '0;
      p_in.kind = MEET_NONE;
      p_in.den  = den_type'(1);
      dpos = (in_data.d < 0) ? -in_data.d : in_data.d;
      par  = (in_data.d == '0) || (den_type'(dpos) < den_type'(threshold));
      upt  = (g.ux == '0) && (g.uy == '0);
      vpt  = (g.vx == '0) && (g.vy == '0);
      wa   = '0;
      va   = '0;
      cden = '0;
      cn0  = '0;
      cn1  = '0;
      tmp  = '0;
      ns   = in_data.cvw;
      nt   = in_data.cuw;
      if (par) begin
         if (in_data.cuw != '0 || in_data.cvw != '0) begin
            p_in.kind = MEET_NONE;
         end else if (upt && vpt) begin
            if (g.wx == '0 && g.wy == '0) begin
               p_in.kind = MEET_POINT;
               p_in.px   = g.ax0;
               p_in.py   = g.ay0;
            end
         end else if (upt) begin
            wa = (g.vx == '0) ? g.wy : g.wx;
            va = (g.vx == '0) ? g.vy : g.vx;
            if ((wa >= 0 && wa <= va) || (wa <= 0 && wa >= va)) begin
               p_in.kind = MEET_POINT;
               p_in.px   = g.ax0;
               p_in.py   = g.ay0;
            end
         end else if (vpt) begin
            wa = (g.ux == '0) ? -g.wy : -g.wx;
            va = (g.ux == '0) ? g.uy : g.ux;
            if ((wa >= 0 && wa <= va) || (wa <= 0 && wa >= va)) begin
               p_in.kind = MEET_POINT;
               p_in.px   = g.bx0;
               p_in.py   = g.by0;
            end
         end else begin
            cden = (g.vx != '0) ? g.vx : g.vy;
            cn0  = (g.vx != '0) ? g.wx : g.wy;
            cn1  = (g.vx != '0) ? g.ex : g.ey;
            if (cden < 0) begin
               cden = -cden;
               cn0  = -cn0;
               cn1  = -cn1;
            end
            if (cn0 > cn1) begin
               tmp = cn0;
               cn0 = cn1;
               cn1 = tmp;
            end
            if (!(cn0 > cden || cn1 < 0)) begin
               if (cn0 < 0) begin
                  cn0 = '0;
               end
               if (cn1 > cden) begin
                  cn1 = cden;
               end
               p_in.kind = (cn0 == cn1) ? MEET_POINT : MEET_SPAN;
               p_in.px   = g.bx0;
               p_in.py   = g.by0;
               p_in.n0   = prod_type'(cn0);
               p_in.n1   = prod_type'(cn1);
               p_in.dirx = g.vx;
               p_in.diry = g.vy;
               p_in.den  = den_type'(cden);
            end
         end
      end else begin
         if (in_data.d < 0) begin
            ns = -ns;
            nt = -nt;
         end
         if (ns >= 0 && ns <= dpos && nt >= 0 && nt <= dpos) begin
            p_in.kind = MEET_POINT;
            p_in.px   = g.ax0;
            p_in.py   = g.ay0;
            p_in.n0   = ns;
            p_in.n1   = ns;
            p_in.dirx = g.ux;
            p_in.diry = g.uy;
            p_in.den  = den_type'(dpos);
         end
      end
   end

   assign out_valid = v_ff;
   assign out_data  = p_ff;

endmodule

@@ rtl/core/sgi_numer.sv @@
// Numerators p*den + n*dir for the four output lanes, then sign and magnitude.
// Depends on sgi_pkg.
module sgi_numer import sgi_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  plan_type  in_data,
   output logic      out_valid,
   output numer_type out_data
);

   logic      va_ff, vb_ff;
   pd_type    pd_ff [0:1];
   nd_type    nd_ff [0:LANES-1];
   meet_type  kind_ff;
   den_type   den_ff;
   numer_type n_ff, n_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      pd_ff[0] <= in_data.px * $signed({1'b0, in_data.den});
      pd_ff[1] <= in_data.py * $signed({1'b0, in_data.den});
      nd_ff[0] <= in_data.n0 * in_data.dirx;
      nd_ff[1] <= in_data.n0 * in_data.diry;
      nd_ff[2] <= in_data.n1 * in_data.dirx;
      nd_ff[3] <= in_data.n1 * in_data.diry;
      kind_ff  <= in_data.kind;
      den_ff   <= in_data.den;
      n_ff     <= n_in;
   end

   always_comb begin
      num_type sum;
      n_in.kind = kind_ff;
      n_in.den  = den_ff;
      for (int k = 0; k < LANES; k++) begin
         sum = num_type'(pd_ff[k % 2]) + num_type'(nd_ff[k]);
         n_in.neg[k] = sum[NUM_W-1];
         n_in.mag[k] = sum[NUM_W-1] ? mag_type'(-sum) : mag_type'(sum);
      end
   end

   assign out_valid = vb_ff;
   assign out_data  = n_ff;

endmodule

@@ rtl/core/sgi_div_pipe.sv @@
// Pipelined restoring divider, one quotient bit per stage, for (mag << FB) / den.
// Depends on sgi_pkg.
module sgi_div_pipe import sgi_pkg::*; (
   input  logic    clock,
   input  mag_type mag,
   input  den_type den,
   output quo_type quo
);

   logic [XW-1:0] x;
   den_type       rem_ff [0:QB];
   den_type       den_ff [0:QB];
   quo_type       sh_ff  [0:QB];

   assign x = XW'(mag) << FB;

   always_ff @(posedge clock) begin
      rem_ff[0] <= den_type'(x >> QB);
      sh_ff[0]  <= quo_type'(x);
      den_ff[0] <= den;
   end

   for (genvar k = 1; k <= QB; k++) begin : g_step
      logic [PROD_W:0] trial;
      logic            fits;
      assign trial = {rem_ff[k-1], sh_ff[k-1][QB-1]};
      assign fits  = trial >= {1'b0, den_ff[k-1]};
      always_ff @(posedge clock) begin
         rem_ff[k] <= fits ? den_type'(trial - {1'b0, den_ff[k-1]}) : den_type'(trial);
         sh_ff[k]  <= {sh_ff[k-1][QB-2:0], fits};
         den_ff[k] <= den_ff[k-1];
      end
   end

   assign quo = sh_ff[QB];

endmodule

@@ rtl/core/segment_intersection_2d.sv @@
// Segment intersection top: threshold register, front, classify, numerators,
// four divider lanes and result register. Depends on sgi_pkg and all rtl/core modules.
// Throughput: one beat per cycle; busy is never raised, the divider lanes are fully pipelined.
// Reset: synchronous; clears all valid bits and loads the threshold with 1.
// The receiver cannot stall: each result is shown for exactly one cycle.
module segment_intersection_2d import sgi_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [FIELD_W-1:0] req_a_start_x,
   input  logic signed [FIELD_W-1:0] req_a_start_y,
   input  logic signed [FIELD_W-1:0] req_a_end_x,
   input  logic signed [FIELD_W-1:0] req_a_end_y,
   input  logic signed [FIELD_W-1:0] req_b_start_x,
   input  logic signed [FIELD_W-1:0] req_b_start_y,
   input  logic signed [FIELD_W-1:0] req_b_end_x,
   input  logic signed [FIELD_W-1:0] req_b_end_y,
   input  logic                      csr_wr_en,
   input  logic [THR_W-1:0]          csr_wr_data,
   output logic                      rsp_valid,
   output logic [1:0]                rsp_meet_kind,
   output logic signed [OUT_W-1:0]   rsp_first_x,
   output logic signed [OUT_W-1:0]   rsp_first_y,
   output logic signed [OUT_W-1:0]   rsp_second_x,
   output logic signed [OUT_W-1:0]   rsp_second_y
);

   logic [THR_W-1:0]   thr_ff;
   logic               f_valid, c_valid, n_valid;
   cross_type          f_data;
   plan_type           c_data;
   numer_type          n_data;
   quo_type            quo [0:LANES-1];
   logic               sv_ff   [0:QB];
   meet_type           skind_ff [0:QB];
   logic [LANES-1:0]   sneg_ff [0:QB];
   logic [OUT_W-1:0]   val [0:LANES-1];
   logic               rv_ff;
   meet_type           rkind_ff;
   logic [OUT_W-1:0]   r_ff [0:LANES-1];

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   sgi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start & ~busy),
      .ax0       (coord_type'(req_a_start_x[CW-1:0])),
      .ay0       (coord_type'(req_a_start_y[CW-1:0])),
      .ax1       (coord_type'(req_a_end_x[CW-1:0])),
      .ay1       (coord_type'(req_a_end_y[CW-1:0])),
      .bx0       (coord_type'(req_b_start_x[CW-1:0])),
      .by0       (coord_type'(req_b_start_y[CW-1:0])),
      .bx1       (coord_type'(req_b_end_x[CW-1:0])),
      .by1       (coord_type'(req_b_end_y[CW-1:0])),
      .out_valid (f_valid),
      .out_data  (f_data)
   );

   sgi_classify u_classify (
      .clock     (clock),
      .reset     (reset),
      .threshold (thr_ff),
      .in_valid  (f_valid),
      .in_data   (f_data),
      .out_valid (c_valid),
      .out_data  (c_data)
   );

   sgi_numer u_numer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_valid),
      .in_data   (c_data),
      .out_valid (n_valid),
      .out_data  (n_data)
   );

   for (genvar k = 0; k < LANES; k++) begin : g_lane
      sgi_div_pipe u_div (
         .clock (clock),
         .mag   (n_data.mag[k]),
         .den   (n_data.den),
         .quo   (quo[k])
      );
      assign val[k] = sneg_ff[QB][k] ? -OUT_W'(quo[k]) : OUT_W'(quo[k]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff[0] <= 1'b0;
      end else begin
         sv_ff[0] <= n_valid;
      end
   end

   always_ff @(posedge clock) begin
      skind_ff[0] <= n_data.kind;
      sneg_ff[0]  <= n_data.neg;
   end

   for (genvar k = 1; k <= QB; k++) begin : g_side
      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[k] <= 1'b0;
         end else begin
            sv_ff[k] <= sv_ff[k-1];
         end
      end
      always_ff @(posedge clock) begin
         skind_ff[k] <= skind_ff[k-1];
         sneg_ff[k]  <= sneg_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= sv_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      rkind_ff <= skind_ff[QB];
      r_ff[0]  <= (skind_ff[QB] != MEET_NONE) ? val[0] : '0;
      r_ff[1]  <= (skind_ff[QB] != MEET_NONE) ? val[1] : '0;
      r_ff[2]  <= (skind_ff[QB] == MEET_SPAN) ? val[2] : '0;
      r_ff[3]  <= (skind_ff[QB] == MEET_SPAN) ? val[3] : '0;
   end

   assign rsp_valid     = rv_ff;
   assign rsp_meet_kind = rkind_ff;
   assign rsp_first_x   = r_ff[0];
   assign rsp_first_y   = r_ff[1];
   assign rsp_second_x  = r_ff[2];
   assign rsp_second_y  = r_ff[3];

endmodule

@@ sim/tb_segment_intersection_2d.sv @@
// Self-checking testbench for segment_intersection_2d: drives segment pairs and
// compares each intersection result against an in-bench exact-arithmetic model.
// Depends on sgi_pkg and the segment_intersection_2d RTL.
`timescale 1ns / 100ps

module tb_segment_intersection_2d;
   import sgi_pkg::*;

   typedef struct {
      logic [1:0]  kind;
      logic [31:0] fx, fy, sx, sy;
   } meet_exp_type;

   localparam int LATENCY   = QB + 8;
   localparam int MAX_CYCLE = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [FIELD_W-1:0] ax0 = '0, ay0 = '0, ax1 = '0, ay1 = '0;
   logic signed [FIELD_W-1:0] bx0 = '0, by0 = '0, bx1 = '0, by1 = '0;
   logic csr_wr_en = 1'b0;
   logic [THR_W-1:0] csr_wr_data = '0;
   logic rsp_valid;
   logic [1:0] rsp_meet_kind;
   logic signed [OUT_W-1:0] rsp_first_x, rsp_first_y, rsp_second_x, rsp_second_y;

   logic [THR_W-1:0] threshold = THR_RESET;
   meet_exp_type pending_meets[$];
   int errors = 0;
   int cycle = 0;

   segment_intersection_2d uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_a_start_x(ax0), .req_a_start_y(ay0), .req_a_end_x(ax1), .req_a_end_y(ay1),
      .req_b_start_x(bx0), .req_b_start_y(by0), .req_b_end_x(bx1), .req_b_end_y(by1),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .rsp_valid(rsp_valid), .rsp_meet_kind(rsp_meet_kind),
      .rsp_first_x(rsp_first_x), .rsp_first_y(rsp_first_y),
      .rsp_second_x(rsp_second_x), .rsp_second_y(rsp_second_y)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > MAX_CYCLE) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // trunc((p*d + n*dir) * 2^FB / d)
   function automatic logic [31:0] fix_point(longint p, longint n, longint dir, longint d);
      logic signed [127:0] num;
      logic signed [127:0] q;
      num = (128'(signed'(p)) * d + 128'(signed'(n)) * dir) <<< FB;
      q = num / 128'(signed'(d));
      return q[31:0];
   endfunction

   function automatic longint cross2(longint px, longint py, longint qx, longint qy);
      return px * qy - py * qx;
   endfunction

   function automatic bit on_range(longint px, longint py, longint s0x, longint s0y,
                                   longint s1x, longint s1y);
      longint a, b, c;
      a = s0x; b = s1x; c = px;
      if (s0x == s1x) begin
         a = s0y; b = s1y; c = py;
      end
      return (a <= c && c <= b) || (a >= c && c >= b);
   endfunction

   function automatic meet_exp_type predict_meet(longint pax, longint pay, longint pbx,
                                                 longint pby, longint qax, longint qay,
                                                 longint qbx, longint qby);
      meet_exp_type r;
      longint ux, uy, vx, vy, wx, wy, d, ad, den, n0, n1, t, ns, nt;
      bit upt, vpt;
      r = '{MEET_NONE, 0, 0, 0, 0};
      ux = pbx - pax; uy = pby - pay;
      vx = qbx - qax; vy = qby - qay;
      wx = pax - qax; wy = pay - qay;
      d = cross2(ux, uy, vx, vy);
      ad = d < 0 ? -d : d;
      if (d == 0 || ad < longint'(threshold)) begin
         upt = (ux == 0 && uy == 0);
         vpt = (vx == 0 && vy == 0);
         if (cross2(ux, uy, wx, wy) != 0 || cross2(vx, vy, wx, wy) != 0) begin
            r.kind = MEET_NONE;
         end else if (upt && vpt) begin
            if (wx == 0 && wy == 0) begin
               r.kind = MEET_POINT; r.fx = fix_point(pax, 0, 0, 1); r.fy = fix_point(pay, 0, 0, 1);
            end
         end else if (upt) begin
            if (on_range(pax, pay, qax, qay, qbx, qby)) begin
               r.kind = MEET_POINT; r.fx = fix_point(pax, 0, 0, 1); r.fy = fix_point(pay, 0, 0, 1);
            end
         end else if (vpt) begin
            if (on_range(qax, qay, pax, pay, pbx, pby)) begin
               r.kind = MEET_POINT; r.fx = fix_point(qax, 0, 0, 1); r.fy = fix_point(qay, 0, 0, 1);
            end
         end else begin
            if (vx != 0) begin
               den = vx; n0 = wx; n1 = pbx - qax;
            end else begin
               den = vy; n0 = wy; n1 = pby - qay;
            end
            if (den < 0) begin
               den = -den; n0 = -n0; n1 = -n1;
            end
            if (n0 > n1) begin
               t = n0; n0 = n1; n1 = t;
            end
            if (!(n0 > den || n1 < 0)) begin
               if (n0 < 0) n0 = 0;
               if (n1 > den) n1 = den;
               r.fx = fix_point(qax, n0, vx, den);
               r.fy = fix_point(qay, n0, vy, den);
               if (n0 == n1) begin
                  r.kind = MEET_POINT;
               end else begin
                  r.kind = MEET_SPAN;
                  r.sx = fix_point(qax, n1, vx, den);
                  r.sy = fix_point(qay, n1, vy, den);
               end
            end
         end
      end else begin
         ns = cross2(vx, vy, wx, wy);
         nt = cross2(ux, uy, wx, wy);
         if (d < 0) begin
            d = -d; ns = -ns; nt = -nt;
         end
         if (ns >= 0 && ns <= d && nt >= 0 && nt <= d) begin
            r.kind = MEET_POINT;
            r.fx = fix_point(pax, ns, ux, d);
            r.fy = fix_point(pay, ns, uy, d);
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      meet_exp_type e;
      if (!reset && rsp_valid) begin
         if (pending_meets.size() == 0) begin
            $error("result beat with nothing expected");
            errors++;
         end else begin
            e = pending_meets.pop_front();
            if (rsp_meet_kind !== e.kind) begin
               $error("meet_kind expected %0d actual %0d", e.kind, rsp_meet_kind); errors++;
            end
            if (rsp_first_x !== e.fx) begin
               $error("first_x expected %h actual %h", e.fx, rsp_first_x); errors++;
            end
            if (rsp_first_y !== e.fy) begin
               $error("first_y expected %h actual %h", e.fy, rsp_first_y); errors++;
            end
            if (rsp_second_x !== e.sx) begin
               $error("second_x expected %h actual %h", e.sx, rsp_second_x); errors++;
            end
            if (rsp_second_y !== e.sy) begin
               $error("second_y expected %h actual %h", e.sy, rsp_second_y); errors++;
            end
         end
      end
   end

   // Drop start only when the drawn gap is not empty.
   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) < 6) ? 0 :
          ($urandom_range(0, 9) < 9) ? $urandom_range(1, 3) : $urandom_range(10, 60);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   // Hold start across back-to-back beats; drop it only on a gap.
   task automatic send_segments(int p0, int p1, int p2, int p3, int q0, int q1, int q2, int q3,
                                bit gaps = 1);
      ax0 <= p0[15:0]; ay0 <= p1[15:0]; ax1 <= p2[15:0]; ay1 <= p3[15:0];
      bx0 <= q0[15:0]; by0 <= q1[15:0]; bx1 <= q2[15:0]; by1 <= q3[15:0];
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_meets.push_back(predict_meet(
         longint'(ax0), longint'(ay0), longint'(ax1), longint'(ay1),
         longint'(bx0), longint'(by0), longint'(bx1), longint'(by1)));
      @(negedge clock);
      if (gaps && $urandom_range(0, 3) == 0) begin
         idle_gap();
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_meets.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic write_threshold(int value);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value[THR_W-1:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
      threshold = value[THR_W-1:0];
   endtask

   function automatic int rnd_coord(int span);
      return $urandom_range(0, 2 * span) - span;
   endfunction

   task automatic test_directed();
      send_segments(0, 0, 10, 10, 0, 10, 10, 0);
      send_segments(0, 0, 10, 0, 0, 1, 10, 1);
      send_segments(0, 0, 10, 0, 5, 0, 20, 0);
      send_segments(0, 0, 10, 0, 10, 0, 20, 0);
      send_segments(0, 0, 10, 0, 11, 0, 20, 0);
      send_segments(0, 5, 0, 5, 0, 5, 0, 5);
      send_segments(0, 5, 0, 5, 0, 6, 0, 6);
      send_segments(3, 0, 3, 0, 0, 0, 10, 0);
      send_segments(0, 4, 0, 4, 0, 0, 0, 10);
      send_segments(0, 0, 10, 10, 4, 4, 4, 4);
      send_segments(0, 0, 0, 10, 0, 12, 0, -3);
      send_segments(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
      send_segments(32767, 32767, -32768, -32768, 32767, 32767, -32768, -32768);
      send_segments(-32768, 0, 32767, 0, 32767, -32768, 32767, 32767);
      send_segments(0, 0, 3, 1, 0, 0, 7, 2);
      send_segments(0, 0, 1, 3, 2, 0, 3, 7);
      send_segments(0, 0, 5, 0, 6, -1, 6, 1);
      send_segments(0, 0, 1, 1, 0, 1, 1, 0);
   endtask

   task automatic test_random(int count, int span);
      int kind, c0, c1, dx, dy, k0, k1;
      repeat (count) begin
         kind = $urandom_range(0, 9);
         if (kind < 4) begin
            send_segments(rnd_coord(span), rnd_coord(span), rnd_coord(span), rnd_coord(span),
                          rnd_coord(span), rnd_coord(span), rnd_coord(span), rnd_coord(span));
         end else if (kind < 7) begin
            c0 = rnd_coord(span / 2); c1 = rnd_coord(span / 2);
            dx = rnd_coord(8); dy = rnd_coord(8);
            k0 = rnd_coord(6); k1 = rnd_coord(6);
            send_segments(c0, c1, c0 + dx * rnd_coord(4), c1 + dy * rnd_coord(4),
                          c0 + dx * k0, c1 + dy * k0, c0 + dx * k1, c1 + dy * k1);
         end else if (kind < 8) begin
            c0 = rnd_coord(span); c1 = rnd_coord(span);
            send_segments(c0, c1, c0, c1, rnd_coord(span), rnd_coord(span),
                          ($urandom_range(0, 1) ? c0 : rnd_coord(span)), rnd_coord(span));
         end else if (kind < 9) begin
            c0 = rnd_coord(20); c1 = rnd_coord(20);
            send_segments(c0, c1, c0 + rnd_coord(5), c1 + rnd_coord(5),
                          c0 + rnd_coord(5), c1 + rnd_coord(5), c0 + rnd_coord(5),
                          c1 + rnd_coord(5));
         end else begin
            send_segments($urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom);
         end
      end
   endtask

   task automatic test_back_to_back();
      repeat (40) send_segments(rnd_coord(100), rnd_coord(100), rnd_coord(100), rnd_coord(100),
                                rnd_coord(100), rnd_coord(100), rnd_coord(100), rnd_coord(100),
                                0);
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_random(150, 32768);
      write_threshold(0);
      test_directed();
      test_random(80, 200);
      write_threshold(1023);
      test_random(120, 30);
      test_back_to_back();
      write_threshold($urandom_range(2, 40));
      test_random(100, 1000);
      write_threshold(1);
      test_random(60, 32768);
      drain();
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
